### rtl/core/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, types and the B3/S23 rule for the Life generation stream.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int CFG_W           = 11;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;
   localparam int ROW_FIELD_W     = 10;
   localparam int COL_FIELD_W     = 10;
   localparam int REQ_TDATA_W     = 8;
   localparam int RSP_TDATA_W     = 24;
   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int MAX_HEIGHT_DEF  = 1024;
   localparam int DIM_MIN         = 3;
   localparam int GRID_WIDTH_RST  = 200;
   localparam int GRID_HEIGHT_RST = 200;
   localparam int WIN_COLS        = 3;
   localparam int WIN_ROWS        = 3;
   localparam int CNT_W           = 2;
   localparam int SUM_W           = 4;
   localparam int BIRTH_COUNT     = 3;
   localparam int SURVIVE_COUNT   = 2;

   typedef enum logic [0:0] {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctrl_type;

   function automatic logic life_next(input logic centre, input logic [SUM_W-1:0] n);
      logic born;
      logic stays;
      born  = (n == SUM_W'(BIRTH_COUNT));
      stays = centre && (n == SUM_W'(SURVIVE_COUNT));
      return born || stays;
   endfunction

endpackage

### rtl/core/life_generation_stream_core.sv
// ----------------------------------------------------------------------------
// life_generation_stream_core
// One B3/S23 Life generation over a raster cell stream with a 3x3 window.
// ----------------------------------------------------------------------------
// Pipeline: an accepted cell is held in stage A, then stage B drives its result.
// Throughput: one cell per clock while the result port is ready; a last-column
// cell after row 0 yields two result beats, so the result port, one beat per
// clock, sets the pace at the row end. Reset: counters, window and pipeline valids
// clear; grid_width and grid_height return to 200. Line buffers are not cleared.
module life_generation_stream_core
   import lgs_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [0] cell_alive
   input  logic                   req_tuser,   // [0] padding_row
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [0] next_alive, [10:1] out_row, [20:11] out_col
   output logic                   rsp_tlast,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WDW  = $clog2(MAX_WIDTH + 1);
   localparam int RW   = $clog2(MAX_HEIGHT + 1);
   localparam int CMPW = ((WDW > RW) ? WDW : RW) > CFG_W ? ((WDW > RW) ? WDW : RW) : CFG_W;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [WDW-1:0]   width_use;
   logic [RW-1:0]    height_use;
   logic             csr_wr;

   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [RW-1:0] row_cnt_ff, row_cnt_in;
   logic          last_col;
   logic          pad_row;
   logic          accept;

   logic          a_valid_ff, a_valid_in;
   logic          a_bot_ff;
   logic [CW-1:0] a_col_ff;
   logic [RW-1:0] a_row_ff;
   logic          a_last_ff;
   logic          a_pad_ff;
   logic          a_adv;

   logic          b_res1_ff, b_res1_in;
   logic          b_res2_ff, b_res2_in;
   logic [CW-1:0] b_col_ff;
   logic [RW-1:0] b_row_ff;
   logic          b_pad_ff;
   logic          b_free;
   logic          rsp_beat;

   logic [1:0]          line_rd;
   logic [WIN_ROWS-1:0] new_col;
   cell_ctrl_type       cell_ctrl [WIN_COLS];
   logic [WIN_ROWS-1:0] cell_in   [WIN_COLS];
   logic [WIN_ROWS-1:0] cell_out  [WIN_COLS];
   logic [CNT_W-1:0]    cell_cnt  [WIN_COLS];
   logic [SUM_W-1:0]    sum_full;
   logic [SUM_W-1:0]    sum_edge;
   logic                alive_full;
   logic                alive_edge;

   logic                   sel_alive;
   logic [ROW_FIELD_W-1:0] sel_row;
   logic [COL_FIELD_W-1:0] sel_col;

   // configuration
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (reg_index_type'(csr_paddr[2]))
            REG_GRID_WIDTH:  width_in  = csr_pwdata[CFG_W-1:0];
            REG_GRID_HEIGHT: height_in = csr_pwdata[CFG_W-1:0];
            default:         width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[2]))
         REG_GRID_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_GRID_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (CMPW'(width_ff) < CMPW'(DIM_MIN)) begin
         width_use = WDW'(DIM_MIN);
      end else if (CMPW'(width_ff) > CMPW'(MAX_WIDTH)) begin
         width_use = WDW'(MAX_WIDTH);
      end else begin
         width_use = WDW'(width_ff);
      end
      if (CMPW'(height_ff) < CMPW'(DIM_MIN)) begin
         height_use = RW'(DIM_MIN);
      end else if (CMPW'(height_ff) > CMPW'(MAX_HEIGHT)) begin
         height_use = RW'(MAX_HEIGHT);
      end else begin
         height_use = RW'(height_ff);
      end
   end

   // raster position
   assign accept   = req_tvalid & req_tready;
   assign last_col = WDW'(col_cnt_ff) >= (width_use - WDW'(1));
   assign pad_row  = row_cnt_ff >= height_use;

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept) begin
         if (last_col) begin
            col_cnt_in = '0;
            row_cnt_in = pad_row ? '0 : row_cnt_ff + RW'(1);
         end else begin
            col_cnt_in = col_cnt_ff + CW'(1);
         end
      end
   end

   // pipeline control
   assign rsp_beat   = rsp_tvalid & rsp_tready;
   assign b_free     = !(b_res1_ff | b_res2_ff) | (rsp_tready & (b_res1_ff ^ b_res2_ff));
   assign a_adv      = a_valid_ff & b_free;
   assign req_tready = !a_valid_ff | b_free;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      b_res1_in = b_res1_ff;
      b_res2_in = b_res2_ff;
      if (a_adv) begin
         b_res1_in = (a_row_ff >= RW'(1)) && (a_col_ff != '0);
         b_res2_in = (a_row_ff >= RW'(1)) && a_last_ff;
      end else if (rsp_beat) begin
         if (b_res1_ff) begin
            b_res1_in = 1'b0;
         end else begin
            b_res2_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= CFG_W'(GRID_WIDTH_RST);
         height_ff  <= CFG_W'(GRID_HEIGHT_RST);
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         a_valid_ff <= 1'b0;
         b_res1_ff  <= 1'b0;
         b_res2_ff  <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         a_valid_ff <= a_valid_in;
         b_res1_ff  <= b_res1_in;
         b_res2_ff  <= b_res2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_bot_ff  <= !pad_row & !req_tuser & req_tdata[0];
         a_col_ff  <= col_cnt_ff;
         a_row_ff  <= row_cnt_ff;
         a_last_ff <= last_col;
         a_pad_ff  <= pad_row;
      end
      if (a_adv) begin
         b_col_ff <= a_col_ff;
         b_row_ff <= a_row_ff;
         b_pad_ff <= a_pad_ff;
      end
   end

   lgs_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_cnt_ff),
      .rd_data (line_rd),
      .wr_en   (a_adv),
      .wr_addr (a_col_ff),
      .wr_data ({line_rd[0], a_bot_ff})
   );

   // window column: bit 0 top, bit 1 middle, bit 2 bottom
   assign new_col = {a_bot_ff,
                     line_rd[0] & (a_row_ff >= RW'(1)),
                     line_rd[1] & (a_row_ff >= RW'(2))};

   for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
      assign cell_ctrl[k].load  = a_adv;
      assign cell_ctrl[k].clear = (k < WIN_COLS - 1) ? (a_col_ff == '0) : 1'b0;
      assign cell_in[k]         = (k == WIN_COLS - 1) ? new_col : cell_out[(k + 1) % WIN_COLS];

      lgs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl[k]),
         .col_in   (cell_in[k]),
         .col_out  (cell_out[k]),
         .live_cnt (cell_cnt[k])
      );
   end

   assign sum_full = SUM_W'(cell_cnt[0]) + SUM_W'(cell_cnt[1]) + SUM_W'(cell_cnt[2])
                     - SUM_W'(cell_out[1][1]);
   assign sum_edge = SUM_W'(cell_cnt[1]) + SUM_W'(cell_cnt[2]) - SUM_W'(cell_out[2][1]);

   assign alive_full = life_next(cell_out[1][1], sum_full);
   assign alive_edge = life_next(cell_out[2][1], sum_edge);

   // result beat: left neighbor first, then the last-column cell
   always_comb begin
      sel_row = ROW_FIELD_W'(b_row_ff - RW'(1));
      if (b_res1_ff) begin
         sel_alive = alive_full;
         sel_col   = COL_FIELD_W'(b_col_ff - CW'(1));
      end else begin
         sel_alive = alive_edge;
         sel_col   = COL_FIELD_W'(b_col_ff);
      end
   end

   assign rsp_tvalid = b_res1_ff | b_res2_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - 1 - ROW_FIELD_W - COL_FIELD_W)'(0),
                        sel_col, sel_row, sel_alive};
   assign rsp_tlast  = !b_res1_ff & b_pad_ff;

endmodule

### rtl/core/lgs_cell.sv
// ----------------------------------------------------------------------------
// lgs_cell
// One window column: holds three vertical cells and their live count.
// ----------------------------------------------------------------------------
module lgs_cell
   import lgs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [WIN_ROWS-1:0] col_in,
   output logic [WIN_ROWS-1:0] col_out,
   output logic [CNT_W-1:0]    live_cnt
);

   logic [WIN_ROWS-1:0] col_ff;
   logic [WIN_ROWS-1:0] col_next_in;

   always_comb begin
      col_next_in = col_ff;
      if (ctrl.load) begin
         col_next_in = ctrl.clear ? '0 : col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_next_in;
      end
   end

   assign col_out  = col_ff;
   assign live_cnt = CNT_W'($countones(col_ff));

endmodule

### rtl/core/lgs_line_store.sv
// ----------------------------------------------------------------------------
// lgs_line_store
// Two line buffers packed per column: bit 1 upper row, bit 0 middle row.
// ----------------------------------------------------------------------------
module lgs_line_store
   import lgs_pkg::*;
#(
   parameter int DEPTH = MAX_WIDTH_DEF,
   parameter int AW    = $clog2(MAX_WIDTH_DEF)
)
(
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [1:0]    rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [1:0]    wr_data
);

   logic [1:0] line_ff [DEPTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### dv/life_generation_stream_core_tb.sv
// ----------------------------------------------------------------------------
// life_generation_stream_core_tb
// Self-checking bench for one B3/S23 Life generation over a raster cell stream.
// Whole frames are streamed in: first a table of directed grids (all-alive,
// all-dead and blinker grids, a glider, clamped grid sizes, padding-flag noise), then
// random grids of random size and density. A line-buffer predictor tracks
// every accepted cell beat and queues the result beats it yields. Each
// result beat is compared field by field, and table rows with a known
// answer also check the live-cell count of the next generation.
// Both stream sides idle and stall at random. One long receiver hold-off
// fills the core.
// ----------------------------------------------------------------------------
module life_generation_stream_core_tb;
   import lgs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_CELLS  = 1150;
   localparam int STALL_LIMIT   = 4000;
   localparam int PRESSURE_HOLD = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int REG_STRIDE    = 4;

   typedef enum logic [2:0] {
      KIND_DEAD,
      KIND_ALIVE,
      KIND_BLINKER,
      KIND_GLIDER,
      KIND_RANDOM
   } frame_kind_type;

   typedef struct packed {
      logic [31:0]    width_val;
      logic [31:0]    height_val;
      frame_kind_type kind;
      logic [7:0]     density;
      logic           pad_noise;
      int             live_next;
   } grid_row_type;

   typedef struct {
      logic                   alive;
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] col;
      logic                   last;
   } cell_result_type;

   localparam grid_row_type DIRECTED_GRIDS [7] = '{
      '{32'd3,          32'd3,    KIND_ALIVE,   8'd0,  1'b0, 4},
      '{32'd3,          32'd3,    KIND_DEAD,    8'd0,  1'b0, 0},
      '{32'd0,          32'd2,    KIND_ALIVE,   8'd0,  1'b0, 4},
      '{32'd5,          32'd5,    KIND_BLINKER, 8'd0,  1'b0, 3},
      '{32'd7,          32'd6,    KIND_GLIDER,  8'd0,  1'b0, 5},
      '{32'd4,          32'd3,    KIND_RANDOM,  8'd50, 1'b1, -1},
      '{32'hFFFF_F809,  32'd5,    KIND_RANDOM,  8'd50, 1'b0, -1}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [0] cell_alive
   logic                   req_tuser;   // [0] padding_row
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [0] next_alive, [10:1] out_row, [20:11] out_col
   logic                   rsp_tlast;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   logic [CFG_W-1:0] grid_width_reg;
   logic [CFG_W-1:0] grid_height_reg;
   logic             upper_mem [MAX_WIDTH_DEF];
   logic             middle_mem [MAX_WIDTH_DEF];
   logic [8:0]       window;
   int               col_pos;
   int               row_pos;

   cell_result_type next_gen_q[$];
   int              frame_live_q[$];
   int              live_tally;
   int              mismatches;
   int              stall_cycles;
   int              cells_sent;
   bit              pressure_req;
   int              send_phase_left;
   bit              send_steady;

   always #1 clock = ~clock;

   life_generation_stream_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
      if (int'(v) < DIM_MIN) return DIM_MIN;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   function automatic logic next_state(input logic [8:0] win);
      int neighbors;
      neighbors = $countones(win) - int'(win[4]);
      return (neighbors == 3) || (win[4] && neighbors == 2);
   endfunction

   task automatic queue_result(input logic alive, input int row, input int col,
                               input logic last);
      cell_result_type r;
      r.alive = alive;
      r.row   = ROW_FIELD_W'(row);
      r.col   = COL_FIELD_W'(col);
      r.last  = last;
      next_gen_q.insert(next_gen_q.size(), r);
   endtask

   task automatic advance_grid(input logic alive_in, input logic pad_flag);
      int         w;
      int         h;
      logic       last_col;
      logic       pad_row;
      logic       bot;
      logic       top;
      logic       mid;
      logic       held;
      logic [2:0] column;
      w        = clamp_dim(grid_width_reg, MAX_WIDTH_DEF);
      h        = clamp_dim(grid_height_reg, MAX_HEIGHT_DEF);
      last_col = (col_pos >= w - 1);
      pad_row  = (row_pos >= h);
      bot      = (!pad_row && !pad_flag) ? alive_in : 1'b0;
      held     = middle_mem[col_pos];
      top      = (row_pos >= 2) ? upper_mem[col_pos] : 1'b0;
      mid      = (row_pos >= 1) ? held : 1'b0;
      upper_mem[col_pos]  = held;
      middle_mem[col_pos] = bot;
      column = {bot, mid, top};
      if (col_pos == 0) begin
         window = {column, 6'b0};
      end else begin
         window = {column, window[8:3]};
      end
      if (row_pos >= 1 && col_pos >= 1) begin
         queue_result(next_state(window), row_pos - 1, col_pos - 1, 1'b0);
      end
      if (row_pos >= 1 && last_col) begin
         queue_result(next_state(window >> 3), row_pos - 1, col_pos, pad_row);
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = pad_row ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endtask

   task automatic check_result();
      cell_result_type        exp;
      logic                   got_alive;
      logic [ROW_FIELD_W-1:0] got_row;
      logic [COL_FIELD_W-1:0] got_col;
      int                     live_exp;
      got_alive = rsp_tdata[0];
      got_row   = rsp_tdata[ROW_FIELD_W:1];
      got_col   = rsp_tdata[ROW_FIELD_W+COL_FIELD_W:ROW_FIELD_W+1];
      if (next_gen_q.size() == 0) begin
         report_mismatch($sformatf("unexpected beat row %0d col %0d", got_row, got_col));
      end else begin
         exp = next_gen_q.pop_front();
         if (got_alive !== exp.alive)
            report_mismatch($sformatf("next_alive %b, want %b at row %0d col %0d",
                                      got_alive, exp.alive, exp.row, exp.col));
         if (got_row !== exp.row)
            report_mismatch($sformatf("out_row %0d, want %0d", got_row, exp.row));
         if (got_col !== exp.col)
            report_mismatch($sformatf("out_col %0d, want %0d", got_col, exp.col));
         if (rsp_tlast !== exp.last)
            report_mismatch($sformatf("frame_last %b, want %b at row %0d col %0d",
                                      rsp_tlast, exp.last, exp.row, exp.col));
      end
      if (got_alive === 1'b1) live_tally++;
      if (rsp_tlast === 1'b1) begin
         if (frame_live_q.size() == 0) begin
            report_mismatch("frame end with no frame outstanding");
         end else begin
            live_exp = frame_live_q.pop_front();
            if (live_exp >= 0 && live_tally != live_exp)
               report_mismatch($sformatf("generation has %0d live cells, want %0d",
                                         live_tally, live_exp));
         end
         live_tally = 0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (req_tvalid && req_tready) begin
            advance_grid(req_tdata[0], req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int next_send_gap();
      if (send_phase_left == 0) begin
         send_phase_left = $urandom_range(20, 200);
         send_steady     = ($urandom_range(0, 2) == 0);
      end
      send_phase_left--;
      if (send_steady || $urandom_range(0, 3) != 0) return 0;
      return gap_len();
   endfunction

   initial begin : rsp_pacing
      int hold_left;
      int phase_left;
      bit steady;
      hold_left  = 0;
      phase_left = 0;
      steady     = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 200);
            steady     = ($urandom_range(0, 2) == 0);
         end
         phase_left--;
         if (pressure_req) begin
            pressure_req = 1'b0;
            hold_left    = PRESSURE_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            hold_left = gap_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * REG_STRIDE);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_GRID_WIDTH) begin
         grid_width_reg = value[CFG_W-1:0];
      end else begin
         grid_height_reg = value[CFG_W-1:0];
      end
      @(posedge clock);
   endtask

   task automatic csr_check(input reg_index_type idx, input logic [CFG_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * REG_STRIDE);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(want))
         report_mismatch($sformatf("%s reads %0d, want %0d", idx.name(), csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(input logic [31:0] width_val, input logic [31:0] height_val);
      csr_write(REG_GRID_WIDTH, width_val);
      csr_write(REG_GRID_HEIGHT, height_val);
      csr_check(REG_GRID_WIDTH, width_val[CFG_W-1:0]);
      csr_check(REG_GRID_HEIGHT, height_val[CFG_W-1:0]);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (next_gen_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_cell(input logic alive, input logic pad_flag);
      int gap;
      gap = next_send_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(alive);
      req_tuser  <= pad_flag;
      do @(posedge clock); while (!req_tready);
      cells_sent++;
   endtask

   function automatic logic cell_value(input frame_kind_type kind, input int r, input int c,
                                       input int w, input int h, input int density);
      case (kind)
         KIND_DEAD:    return 1'b0;
         KIND_ALIVE:   return 1'b1;
         KIND_BLINKER: return (c == w / 2) && (r >= h / 2 - 1) && (r <= h / 2 + 1);
         KIND_GLIDER:  return (r == 1 && c == 2) || (r == 2 && c == 3) ||
                              (r == 3 && c >= 1 && c <= 3);
         default:      return $urandom_range(0, 99) < density;
      endcase
   endfunction

   task automatic send_frame(input frame_kind_type kind, input int density,
                             input logic pad_noise, input int live_next);
      int   w;
      int   h;
      logic alive;
      logic pad_flag;
      w = clamp_dim(grid_width_reg, MAX_WIDTH_DEF);
      h = clamp_dim(grid_height_reg, MAX_HEIGHT_DEF);
      frame_live_q.insert(frame_live_q.size(), live_next);
      for (int r = 0; r <= h; r++) begin
         for (int c = 0; c < w; c++) begin
            if (r < h) begin
               alive    = cell_value(kind, r, c, w, h, density);
               pad_flag = pad_noise && ($urandom_range(0, 9) == 0);
            end else begin
               alive    = 1'($urandom_range(0, 1));
               pad_flag = 1'($urandom_range(0, 1));
            end
            send_cell(alive, pad_flag);
         end
      end
   endtask

   function automatic logic [31:0] random_dim();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(3, 8);
      if (roll < 88) return $urandom_range(9, 20);
      if (roll < 94) return $urandom_range(0, 2);
      return ($urandom() & 32'hFFFF_F800) | 32'($urandom_range(3, 8));
   endfunction

   initial begin : stimulus
      int             start_cells;
      int             roll;
      frame_kind_type kind;
      bit             noise;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= 1'b0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      grid_width_reg  = CFG_W'(GRID_WIDTH_RST);
      grid_height_reg = CFG_W'(GRID_HEIGHT_RST);
      foreach (upper_mem[i]) begin
         upper_mem[i]  = 1'b0;
         middle_mem[i] = 1'b0;
      end
      window          = '0;
      col_pos         = 0;
      row_pos         = 0;
      live_tally      = 0;
      mismatches      = 0;
      stall_cycles    = 0;
      cells_sent      = 0;
      pressure_req    = 1'b0;
      send_phase_left = 0;
      send_steady     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      csr_check(REG_GRID_WIDTH, CFG_W'(GRID_WIDTH_RST));
      csr_check(REG_GRID_HEIGHT, CFG_W'(GRID_HEIGHT_RST));
      set_grid(32'hFFFF_FFFF, 32'd2047);

      foreach (DIRECTED_GRIDS[i]) begin
         drain_results();
         set_grid(DIRECTED_GRIDS[i].width_val, DIRECTED_GRIDS[i].height_val);
         send_frame(DIRECTED_GRIDS[i].kind, int'(DIRECTED_GRIDS[i].density),
                    DIRECTED_GRIDS[i].pad_noise, DIRECTED_GRIDS[i].live_next);
      end

      drain_results();
      set_grid(32'd24, 32'd12);
      pressure_req = 1'b1;
      send_frame(KIND_RANDOM, 40, 1'b0, -1);

      start_cells = cells_sent;
      while (cells_sent - start_cells < RANDOM_CELLS) begin
         if ($urandom_range(0, 9) < 4) begin
            drain_results();
            set_grid(random_dim(), random_dim());
         end
         roll  = $urandom_range(0, 99);
         kind  = (roll < 6) ? KIND_ALIVE : (roll < 12) ? KIND_DEAD : KIND_RANDOM;
         noise = ($urandom_range(0, 4) == 0);
         send_frame(kind, $urandom_range(10, 90), noise, -1);
      end

      drain_results();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
